@@ rtl/amw_pkg.sv @@
package amw_pkg;

  // Request action codes
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_BEGIN  = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_VOLTS_PER_COUNT = 3'd0;
  localparam logic [2:0] REG_OFFSET_PRESET   = 3'd1;
  localparam logic [2:0] REG_SCALE_GAIN      = 3'd2;
  localparam logic [2:0] REG_CAL_SLOPE       = 3'd3;
  localparam logic [2:0] REG_CAL_INTERCEPT   = 3'd4;
  localparam logic [2:0] REG_CREST_MIN_RMS   = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Fixed field widths
  localparam int VOLT_W   = 20;
  localparam int OFFS_W   = 21;
  localparam int VALUE_W  = 32;
  localparam int RMS_W    = 31;
  localparam int CREST_W  = 16;
  localparam int TOTAL_W  = 17;
  localparam int VSUM_W   = 40;
  localparam int SQSUM_W  = 64;

  localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

endpackage

@@ rtl/amw_in_if.sv @@
interface amw_in_if #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output action, output adc_sample, input ready);
  modport sink   (input valid, input action, input adc_sample, output ready);
endinterface

@@ rtl/amw_out_if.sv @@
interface amw_out_if #(
  parameter int ADC_BITS = 10
);
  logic                                 valid;
  logic                                 ready;
  logic signed [amw_pkg::VALUE_W-1:0]   inst_value;
  logic        [amw_pkg::RMS_W-1:0]     rms_value;
  logic        [amw_pkg::CREST_W-1:0]   crest_factor;
  logic signed [amw_pkg::VALUE_W-1:0]   max_value;
  logic signed [amw_pkg::VALUE_W-1:0]   min_value;
  logic        [amw_pkg::TOTAL_W-1:0]   sample_total;
  logic signed [amw_pkg::OFFS_W-1:0]    live_offset;
  logic                                 no_samples;
  logic        [ADC_BITS-1:0]           last_raw;
  logic        [amw_pkg::VOLT_W-1:0]    last_voltage;

  modport source (output valid, output inst_value, output rms_value, output crest_factor,
                  output max_value, output min_value, output sample_total,
                  output live_offset, output no_samples, output last_raw,
                  output last_voltage, input ready);
  modport sink   (input valid, input inst_value, input rms_value, input crest_factor,
                  input max_value, input min_value, input sample_total,
                  input live_offset, input no_samples, input last_raw,
                  input last_voltage, output ready);
endinterface

@@ rtl/ac_rms_window_meter.sv @@
// True-RMS window meter with crest factor. Each request carries an action: take a
// sample (convert the ADC reading to volts, remove the live DC offset, scale,
// calibrate, saturate to 32 bits and accumulate sum, sum of squares, min, max and a
// count), begin a window (clear it) or end a window (load the offset with the mean
// voltage). Every request returns one result with the measurements as they stand
// after the action. One request is in work at a time; in_chan.ready is high only
// while the sequencer is idle and out of reset, and a finished result waits in an
// output register so the next request can be taken before it is drained. A sample
// runs through S_MUL1, S_MUL2, S_MUL3, S_ROUND, S_SQ and S_ACC; an end with
// samples first divides for the mean. Then, with a non-empty window, the sequencer
// divides the sum of squares by the count, takes the square root and, when the RMS
// is above crest_min_rms and the max is positive, divides for the crest factor;
// S_RMS0, S_ROOT0 and S_CREST0 set up these steps, and S_DONE hands the result to
// the result register. A result that is not drained holds the sequencer in its
// hand-off state. All of the division and root steps run one bit (root: one digit)
// per cycle on a single shared 35-bit compare/subtract unit.
module ac_rms_window_meter #(
  parameter int ADC_BITS   = 10,
  parameter int MAX_WINDOW = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  amw_in_if.sink                             in_chan,
  amw_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [amw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [amw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_WINDOW);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL1   = 4'd1;
  localparam logic [3:0] S_MUL2   = 4'd2;
  localparam logic [3:0] S_MUL3   = 4'd3;
  localparam logic [3:0] S_ROUND  = 4'd4;
  localparam logic [3:0] S_SQ     = 4'd5;
  localparam logic [3:0] S_ACC    = 4'd6;
  localparam logic [3:0] S_MEAN   = 4'd7;
  localparam logic [3:0] S_RMS0   = 4'd8;
  localparam logic [3:0] S_MSQ    = 4'd9;
  localparam logic [3:0] S_ROOT0  = 4'd10;
  localparam logic [3:0] S_ROOT   = 4'd11;
  localparam logic [3:0] S_CREST0 = 4'd12;
  localparam logic [3:0] S_CREST  = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  // Configuration
  logic        [15:0]                    vpc_r;
  logic signed [15:0]                    gain_r;
  logic signed [15:0]                    slope_r;
  logic signed [31:0]                    icept_r;
  logic        [15:0]                    crest_min_r;

  // Window state
  logic        [amw_pkg::VSUM_W-1:0]     vsum_r;
  logic        [amw_pkg::SQSUM_W-1:0]    sqsum_r;
  logic signed [amw_pkg::VALUE_W-1:0]    peak_hi_r;
  logic signed [amw_pkg::VALUE_W-1:0]    peak_lo_r;
  logic        [CNT_W-1:0]               count_r;
  logic signed [amw_pkg::OFFS_W-1:0]     offset_r;
  logic        [ADC_BITS-1:0]            raw_r;
  logic        [amw_pkg::VOLT_W-1:0]     volt_r;
  logic signed [amw_pkg::VALUE_W-1:0]    value_r;

  // Sequencer and shared unit
  logic [3:0]          state_r, state_nxt;
  logic [6:0]          iter_r;
  logic signed [53:0]  prod_r;
  logic [63:0]         num_r;
  logic [32:0]         rem_r;
  logic [31:0]         div_r;
  logic [amw_pkg::RMS_W-1:0]   rms_r;
  logic [amw_pkg::CREST_W-1:0] crest_r;
  logic                out_valid_r;

  logic [34:0] su_a, su_b;
  logic [35:0] su_diff;
  logic        su_take;

  logic [ADC_BITS+15:0] volts_full;
  logic signed [21:0]   real_v;
  logic signed [54:0]   rnd;
  logic signed [24:0]   shifted;
  logic signed [32:0]   val_wide;
  logic signed [31:0]   val_sat;
  logic [31:0]          mag;
  logic [64:0]          sq_add;
  logic                 win_open;
  logic                 accept;
  logic                 out_free;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign win_open = count_r < CNT_FULL;

  // Hold off requests during reset so nothing is taken that the sequencer drops
  assign in_chan.ready = rst_n && (state_r == S_IDLE);

  // Shared compare/subtract: long division takes one quotient bit, the root one digit
  always_comb begin
    if (state_r == S_ROOT) begin
      su_a = {rem_r, num_r[63:62]};
      su_b = {1'b0, div_r, 2'b01};
    end else begin
      su_a = {1'b0, rem_r, num_r[63]};
      su_b = {3'b000, div_r};
    end
    su_diff = {1'b0, su_a} - {1'b0, su_b};
    su_take = !su_diff[35];
  end

  // Sample datapath pieces
  always_comb begin
    volts_full = ADC_BITS'(raw_r) * vpc_r;
    real_v     = $signed({2'b00, volt_r}) - $signed({offset_r[20], offset_r});
    rnd        = $signed({prod_r[53], prod_r}) + $signed(55'd536870912);
    shifted    = rnd[54:30];
    val_wide   = $signed({{8{shifted[24]}}, shifted}) + $signed({icept_r[31], icept_r});
    if (val_wide > $signed(33'sh0_7FFF_FFFF)) begin
      val_sat = 32'sh7FFF_FFFF;
    end else if (val_wide < $signed(-33'sh0_8000_0000)) begin
      val_sat = 32'sh8000_0000;
    end else begin
      val_sat = val_wide[31:0];
    end
    mag    = value_r[31] ? (~value_r + 32'd1) : value_r;
    sq_add = {1'b0, sqsum_r} + {1'b0, num_r};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_chan.action)
            amw_pkg::ACT_SAMPLE: state_nxt = S_MUL1;
            amw_pkg::ACT_END:    state_nxt = (count_r != '0) ? S_MEAN : S_RMS0;
            default:             state_nxt = S_RMS0;
          endcase
        end
      end
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_MUL3;
      S_MUL3:   state_nxt = S_ROUND;
      S_ROUND:  state_nxt = S_SQ;
      S_SQ:     state_nxt = S_ACC;
      S_ACC:    state_nxt = S_RMS0;
      S_MEAN:   state_nxt = (iter_r == '0) ? S_RMS0 : S_MEAN;
      S_RMS0:   state_nxt = (count_r == '0) ? S_DONE : S_MSQ;
      S_MSQ:    state_nxt = (iter_r == '0) ? S_ROOT0 : S_MSQ;
      S_ROOT0:  state_nxt = S_ROOT;
      S_ROOT:   state_nxt = (iter_r == '0) ? S_CREST0 : S_ROOT;
      S_CREST0: state_nxt = ((rms_r > 31'(crest_min_r)) && (peak_hi_r > 0)) ? S_CREST : S_DONE;
      S_CREST:  state_nxt = (iter_r == '0) ? S_DONE : S_CREST;
      S_DONE:   state_nxt = out_free ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vpc_r       <= 16'd320;
      gain_r      <= 16'sd256;
      slope_r     <= 16'sd16384;
      icept_r     <= '0;
      crest_min_r <= 16'd13;
      offset_r    <= '0;
      vsum_r      <= '0;
      sqsum_r     <= '0;
      peak_hi_r   <= '0;
      peak_lo_r   <= '0;
      count_r     <= '0;
      raw_r       <= '0;
      volt_r      <= '0;
      value_r     <= '0;
      iter_r      <= '0;
    end else begin
      state_r <= state_nxt;

      // Register writes are to arrive only while idle; the user is bound to this, the block does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          amw_pkg::REG_VOLTS_PER_COUNT: vpc_r       <= cfg_data[15:0];
          amw_pkg::REG_OFFSET_PRESET:   offset_r    <= cfg_data[20:0];
          amw_pkg::REG_SCALE_GAIN:      gain_r      <= cfg_data[15:0];
          amw_pkg::REG_CAL_SLOPE:       slope_r     <= cfg_data[15:0];
          amw_pkg::REG_CAL_INTERCEPT:   icept_r     <= cfg_data;
          amw_pkg::REG_CREST_MIN_RMS:   crest_min_r <= cfg_data[15:0];
          default: ;
        endcase
      end

      // Raise valid as a result is loaded, drop it once drained
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_chan.action == amw_pkg::ACT_SAMPLE) begin
              raw_r <= in_chan.adc_sample;
            end else if (in_chan.action == amw_pkg::ACT_BEGIN) begin
              count_r   <= '0;
              vsum_r    <= '0;
              sqsum_r   <= '0;
              peak_hi_r <= '0;
              peak_lo_r <= '0;
            end else if (in_chan.action == amw_pkg::ACT_END) begin
              num_r  <= {vsum_r, 24'd0};
              rem_r  <= '0;
              div_r  <= 32'(count_r);
              iter_r <= 7'd39;
            end
          end
        end
        S_MUL1: begin
          // Volts, saturated to the 20-bit range
          if (volts_full > (ADC_BITS + 16)'(amw_pkg::VOLT_MAX)) begin
            volt_r <= amw_pkg::VOLT_MAX;
          end else begin
            volt_r <= volts_full[amw_pkg::VOLT_W-1:0];
          end
        end
        S_MUL2: prod_r <= 54'(real_v * gain_r);
        S_MUL3: prod_r <= $signed(prod_r[37:0]) * slope_r;
        S_ROUND: value_r <= val_sat;
        S_SQ: num_r <= mag * mag;
        S_ACC: begin
          if (win_open) begin
            count_r <= count_r + 1'b1;
            vsum_r  <= vsum_r + amw_pkg::VSUM_W'(volt_r);
            sqsum_r <= sq_add[64] ? '1 : sq_add[63:0];
            if (value_r > peak_hi_r) peak_hi_r <= value_r;
            if (value_r < peak_lo_r) peak_lo_r <= value_r;
          end
        end
        S_MEAN, S_MSQ, S_CREST: begin
          // One restoring-division step
          if (su_take) rem_r <= su_diff[32:0];
          else         rem_r <= su_a[32:0];
          num_r  <= {num_r[62:0], su_take};
          iter_r <= iter_r - 1'b1;
          if (iter_r == '0) begin
            if (state_r == S_MEAN) begin
              offset_r <= {1'b0, num_r[18:0], su_take};
            end else if (state_r == S_CREST) begin
              if (num_r[38:15] != '0) crest_r <= '1;
              else                    crest_r <= {num_r[14:0], su_take};
            end
          end
        end
        S_RMS0: begin
          rms_r   <= '0;
          crest_r <= '0;
          num_r   <= sqsum_r;
          rem_r   <= '0;
          div_r   <= 32'(count_r);
          iter_r  <= 7'd63;
        end
        S_ROOT0: begin
          rem_r  <= '0;
          div_r  <= '0;
          iter_r <= 7'd31;
        end
        S_ROOT: begin
          // One digit of the square root; the root builds up in div_r
          if (su_take) begin
            rem_r <= su_diff[32:0];
            div_r <= {div_r[30:0], 1'b1};
          end else begin
            rem_r <= su_a[32:0];
            div_r <= {div_r[30:0], 1'b0};
          end
          num_r  <= {num_r[61:0], 2'b00};
          iter_r <= iter_r - 1'b1;
          if (iter_r == '0) begin
            if (div_r[30]) rms_r <= '1;
            else           rms_r <= {div_r[29:0], su_take};
          end
        end
        S_CREST0: begin
          crest_r <= '0;
          num_r   <= {1'b0, peak_hi_r[30:0], 8'd0, 24'd0};
          rem_r   <= '0;
          div_r   <= {1'b0, rms_r};
          iter_r  <= 7'd39;
        end
        default: ;
      endcase
    end
  end

  // Result register, loaded as the request finishes
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_chan.inst_value   <= value_r;
      out_chan.rms_value    <= rms_r;
      out_chan.crest_factor <= crest_r;
      out_chan.max_value    <= peak_hi_r;
      out_chan.min_value    <= peak_lo_r;
      out_chan.sample_total <= amw_pkg::TOTAL_W'(count_r);
      out_chan.live_offset  <= offset_r;
      out_chan.no_samples   <= (count_r == '0);
      out_chan.last_raw     <= raw_r;
      out_chan.last_voltage <= volt_r;
    end
  end

  assign out_chan.valid = out_valid_r;

endmodule
